[src/lsd_pkg.sv]
// Shared types, codes and helpers for the addressable LED strip driver.
package lsd_pkg;

	// Item kinds; the fourth code does nothing
	typedef enum logic [1:0] {
		KIND_WRITE   = 2'd0,
		KIND_REFRESH = 2'd1,
		KIND_TICK    = 2'd2
	} kind_t;

	// Configuration register indexes
	localparam logic [2:0] REG_SLOT_PERIOD = 3'd0;
	localparam logic [2:0] REG_ZERO_HIGH   = 3'd1;
	localparam logic [2:0] REG_ONE_HIGH    = 3'd2;
	localparam logic [2:0] REG_RESET_SLOTS = 3'd3;
	localparam logic [2:0] REG_LED_COUNT   = 3'd4;

	// Configuration reset values
	localparam logic [15:0] SLOT_PERIOD_RST = 16'd104;
	localparam logic [15:0] ZERO_HIGH_RST   = 16'd29;
	localparam logic [15:0] ONE_HIGH_RST    = 16'd58;
	localparam logic [9:0]  RESET_SLOTS_RST = 10'd64;
	localparam logic [8:0]  LED_COUNT_RST   = 9'd256;

	localparam logic [4:0] BITS_PER_LED = 5'd24;

	typedef struct packed {
		logic [15:0] slot_period;
		logic [15:0] zero_high;
		logic [15:0] one_high;
		logic [9:0]  reset_slots;
		logic [8:0]  led_count;
	} cfg_t;

	typedef struct packed {
		logic        sending;
		logic        in_reset;
		logic [8:0]  led_pos;
		logic [4:0]  bit_pos;
		logic [23:0] color;
		logic [15:0] tick;
		logic [9:0]  rslot;
	} seq_state_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
		logic request_dropped;
	} result_t;

	// Line level driven by a sequencer state during its next tick
	function automatic logic level_of(input seq_state_t st, input cfg_t cfg);
		logic [15:0] high;
		high = st.color[23] ? cfg.one_high : cfg.zero_high;
		return st.sending && !st.in_reset && (st.tick < high);
	endfunction

endpackage

[src/lsd_pixel_mem.sv]
// Pixel store: synchronous RAM with post-reset clearing sweep and write bypass.
module lsd_pixel_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [23:0]   wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [23:0]   rd_data,
	output logic          clearing
);
	logic [23:0]   mem [DEPTH];
	logic [23:0]   rd_q;
	logic          byp_q;
	logic [23:0]   byp_data_q;
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [23:0]   wd;

	// Clearing sweep owns the write port after reset
	assign we = clr_q | wr_en;
	assign wa = clr_q ? clr_addr_q : wr_addr;
	assign wd = clr_q ? 24'd0 : wr_data;
	assign clearing = clr_q;

	// Sweep one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// Storage array, read-first
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[rd_addr];
	end

	// Forward a write that hits the address being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= we && (wa == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wd;
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

[src/lsd_frame_seq.sv]
// Frame sequencer: per-item state update, waveform timing and pixel prefetch.
module lsd_frame_seq #(
	parameter int MAX_LEDS = 256,
	parameter int AW       = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        kind,
	input  logic [7:0]        pixel_index,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  lsd_pkg::cfg_t     cfg,
	input  logic [23:0]       pix_next,
	output logic              pix_we,
	output logic [AW-1:0]     pix_waddr,
	output logic [23:0]       pix_wdata,
	output logic [AW-1:0]     pix_raddr,
	output lsd_pkg::result_t  result,
	output logic              sending
);
	import lsd_pkg::*;

	seq_state_t  st_q;
	seq_state_t  st_d;
	seq_state_t  st_nx;
	logic [8:0]  eff;
	logic [8:0]  led_inc;
	logic        idx_over;
	logic        fin;
	logic        dropped;
	logic        wr_ok;
	logic [31:0] rd_next;

	// Effective LED count saturates at the store depth
	assign eff      = (32'(cfg.led_count) > MAX_LEDS) ? 9'(MAX_LEDS) : cfg.led_count;
	assign idx_over = 32'(pixel_index) >= MAX_LEDS;
	assign led_inc  = st_q.led_pos + 9'd1;

	// Next state and result for the item at the input
	always_comb begin
		st_d    = st_q;
		fin     = 1'b0;
		dropped = 1'b0;
		wr_ok   = 1'b0;
		case (kind)
			KIND_WRITE: begin
				if (st_q.sending || ({1'b0, pixel_index} >= eff) || idx_over) begin
					dropped = 1'b1;
				end else begin
					wr_ok = 1'b1;
				end
			end
			KIND_REFRESH: begin
				if (st_q.sending) begin
					dropped = 1'b1;
				end else begin
					st_d.sending  = 1'b1;
					st_d.in_reset = 1'b0;
					st_d.led_pos  = '0;
					st_d.bit_pos  = '0;
					st_d.tick     = '0;
					st_d.rslot    = '0;
					st_d.color    = pix_next;
				end
			end
			KIND_TICK: begin
				if (st_q.sending) begin
					if (st_q.tick < cfg.slot_period) begin
						st_d.tick = st_q.tick + 16'd1;
					end else begin
						st_d.tick = '0;
						if (st_q.in_reset) begin
							st_d.rslot = st_q.rslot + 10'd1;
							if (st_d.rslot >= cfg.reset_slots) begin
								fin = 1'b1;
							end
						end else begin
							st_d.color   = {st_q.color[22:0], 1'b0};
							st_d.bit_pos = st_q.bit_pos + 5'd1;
							if (st_q.bit_pos == BITS_PER_LED - 5'd1) begin
								st_d.bit_pos = '0;
								if (led_inc >= eff) begin
									st_d.led_pos = '0;
									st_d.color   = '0;
									if (cfg.reset_slots == 10'd0) begin
										fin = 1'b1;
									end else begin
										st_d.in_reset = 1'b1;
										st_d.rslot    = '0;
									end
								end else begin
									st_d.led_pos = led_inc;
									st_d.color   = pix_next;
								end
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
		// End the frame
		if (fin) begin
			st_d.sending  = 1'b0;
			st_d.in_reset = 1'b0;
			st_d.rslot    = '0;
		end
	end

	// Result fields
	always_comb begin
		result.line_level      = (kind == KIND_TICK) ? level_of(st_q, cfg) : level_of(st_d, cfg);
		result.busy_res        = st_d.sending;
		result.frame_done      = fin;
		result.request_dropped = dropped;
	end

	// Advance state on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= st_d;
		end
	end

	// Pixel store write, GRB order
	assign pix_we    = accept && wr_ok;
	assign pix_waddr = AW'(pixel_index);
	assign pix_wdata = {green, red, blue};

	// Prefetch from the state of the next cycle: next LED, or pixel zero while idle
	always_comb begin
		st_nx   = accept ? st_d : st_q;
		rd_next = st_nx.sending ? (32'(st_nx.led_pos) + 32'd1) : 32'd0;
		if (rd_next >= 32'(MAX_LEDS)) begin
			rd_next = 32'd0;
		end
	end
	assign pix_raddr = AW'(rd_next);

	assign sending = st_q.sending;

endmodule

[src/lsd_out_skid.sv]
// Result register with skid stage so the input side keeps flowing.
module lsd_out_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lsd_pkg::result_t push_data,
	output logic             can_push,
	output logic             out_valid,
	input  logic             out_ready,
	output lsd_pkg::result_t out_data
);
	import lsd_pkg::*;

	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;

	assign can_push  = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && out_ready) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			if (!out_v_q) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (out_v_q && out_ready) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			if (!out_v_q) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

[src/addressable_led_strip_driver.sv]
// Top level of the addressable LED strip driver.
//
// Usage: items enter on the item channel (item_valid/item_ready) with a kind
// of pixel write, refresh or timer tick; each item gives exactly one result
// on the result channel (result_valid/result_ready). Registers are written
// through cfg_we/cfg_index/cfg_data at any edge with cfg_we high.
// Results: each result is registered in the output register, or in the skid
// stage while that register is held. One item per cycle while item_ready is
// high; the pixel store is a single-port-write, registered-read RAM whose
// next pixel is prefetched during a frame, so ticks may arrive back to back.
// Reset: registers take their default values, the frame stops, and the
// pixel store is cleared by a sweep over all MAX_LEDS entries, during which
// item_ready stays low; configuration writes are taken meanwhile.
// Stall: a result waiting on result_ready sits in the output register and
// one more in a skid stage; item_ready also drops while the skid is full.
module addressable_led_strip_driver #(
	parameter int MAX_LEDS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  pixel_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        line_level,
	output logic        busy_res,
	output logic        frame_done,
	output logic        request_dropped,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import lsd_pkg::*;

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	cfg_t          cfg_q;
	logic          accept;
	logic          can_push;
	logic          clearing;
	logic          pix_we;
	logic [AW-1:0] pix_waddr;
	logic [23:0]   pix_wdata;
	logic [AW-1:0] pix_raddr;
	logic [23:0]   pix_next;
	logic          sending;
	result_t       res_in;
	result_t       res_out;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_period <= SLOT_PERIOD_RST;
			cfg_q.zero_high   <= ZERO_HIGH_RST;
			cfg_q.one_high    <= ONE_HIGH_RST;
			cfg_q.reset_slots <= RESET_SLOTS_RST;
			cfg_q.led_count   <= LED_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOT_PERIOD: cfg_q.slot_period <= cfg_data;
				REG_ZERO_HIGH:   cfg_q.zero_high   <= cfg_data;
				REG_ONE_HIGH:    cfg_q.one_high    <= cfg_data;
				REG_RESET_SLOTS: cfg_q.reset_slots <= cfg_data[9:0];
				REG_LED_COUNT:   cfg_q.led_count   <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	// Hold off items during the clearing sweep and while the skid is full
	assign item_ready = can_push && !clearing;
	assign accept     = item_valid && item_ready;

	lsd_frame_seq #(
		.MAX_LEDS (MAX_LEDS),
		.AW       (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.kind        (kind),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.cfg         (cfg_q),
		.pix_next    (pix_next),
		.pix_we      (pix_we),
		.pix_waddr   (pix_waddr),
		.pix_wdata   (pix_wdata),
		.pix_raddr   (pix_raddr),
		.result      (res_in),
		.sending     (sending)
	);

	lsd_pixel_mem #(
		.DEPTH (MAX_LEDS),
		.AW    (AW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (pix_we),
		.wr_addr  (pix_waddr),
		.wr_data  (pix_wdata),
		.rd_addr  (pix_raddr),
		.rd_data  (pix_next),
		.clearing (clearing)
	);

	lsd_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res_in),
		.can_push  (can_push),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_data  (res_out)
	);

	assign line_level      = res_out.line_level;
	assign busy_res        = res_out.busy_res;
	assign frame_done      = res_out.frame_done;
	assign request_dropped = res_out.request_dropped;

	// A finished frame reports idle and never drops in the same transaction
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_done |-> !busy_res && !request_dropped)
		else $error("frame_done with busy or dropped");

	// The pixel store is never written while a frame is on the line
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pix_we |-> !sending && !clearing)
		else $error("pixel write during frame or clear");

	// No transaction is taken during the clearing sweep
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !item_ready)
		else $error("item accepted during clear");

	// A refresh taken while idle starts a frame (sending goes high)
	a_refresh_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (kind == KIND_REFRESH) && !sending |=> sending)
		else $error("refresh did not start a frame");

endmodule
